FILE: design/utd_pkg.sv
// utd_pkg: shared types and constants for the utf-8 to utf-16 decoder
// no dependencies; used by every module in design/
`default_nettype none

package utd_pkg;

  // one input request as held in the input register
  typedef struct packed {
    logic [7:0] in_byte;
    logic       text_last;
  } item_t;

  // one result request as held in the output register
  typedef struct packed {
    logic [15:0] code_unit;
    logic        unit_valid;
    logic        text_end;
  } result_t;

  // continuation bytes still owed by the open sequence
  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_ONE  = 2'd1;
  localparam logic [1:0] PEND_TWO  = 2'd2;

  // lead byte classes, compared under their masks
  localparam logic [7:0] ASCII_MASK = 8'h80;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_CODE = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_CODE = 8'hE0;

  // payload bits of each byte kind
  localparam logic [7:0] LEAD2_BITS = 8'h1F;
  localparam logic [7:0] LEAD3_BITS = 8'h0F;
  localparam logic [7:0] CONT_BITS  = 8'h3F;

endpackage

`default_nettype wire

FILE: design/utd_in_reg.sv
// utd_in_reg: input register for one byte request
// depends on utd_pkg (item_t)
`default_nettype none

module utd_in_reg (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [7:0]   in_byte,
  input  wire logic         in_text_last,
  input  wire logic         take,
  output logic              item_valid,
  output utd_pkg::item_t    item
);

  logic           valid_r;
  logic           valid_nxt;
  utd_pkg::item_t item_r;

  assign in_ready   = !valid_r || take;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.in_byte   <= in_byte;
      item_r.text_last <= in_text_last;
    end
  end

endmodule

`default_nettype wire

FILE: design/utd_core.sv
// utd_core: sequence state and per-byte decode into a utf-16 code unit
// depends on utd_pkg (item_t, result_t, byte class constants)
`default_nettype none

module utd_core (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            item_valid,
  input  wire utd_pkg::item_t  item,
  input  wire logic            out_free,
  output logic                 take,
  output logic                 res_valid,
  output utd_pkg::result_t     res
);

  logic [1:0]  pending_r;
  logic [1:0]  pending_nxt;
  logic [15:0] partial_r;
  logic [15:0] partial_nxt;
  logic        done;
  logic [15:0] unit;
  logic [7:0]  b;

  assign b    = item.in_byte;
  assign take = item_valid && out_free;

  always_comb begin
    pending_nxt = pending_r;
    partial_nxt = partial_r;
    done        = 1'b0;
    unit        = 16'h0000;
    case (pending_r)
      utd_pkg::PEND_NONE: begin
        if ((b & utd_pkg::ASCII_MASK) == 8'h00) begin
          unit = {8'h00, b};
          done = 1'b1;
        end else if ((b & utd_pkg::LEAD2_MASK) == utd_pkg::LEAD2_CODE) begin
          partial_nxt = {5'b0, b[4:0] & utd_pkg::LEAD2_BITS[4:0], 6'b0};
          pending_nxt = utd_pkg::PEND_ONE;
        end else if ((b & utd_pkg::LEAD3_MASK) == utd_pkg::LEAD3_CODE) begin
          partial_nxt = {b[3:0] & utd_pkg::LEAD3_BITS[3:0], 12'b0};
          pending_nxt = utd_pkg::PEND_TWO;
        end
        // stray continuations and four-byte leads fall through unused
      end
      utd_pkg::PEND_ONE: begin
        unit        = partial_r | {10'b0, b[5:0] & utd_pkg::CONT_BITS[5:0]};
        done        = 1'b1;
        pending_nxt = utd_pkg::PEND_NONE;
        partial_nxt = 16'h0000;
      end
      default: begin
        // middle byte of a three-byte sequence; a count of three never occurs
        partial_nxt = partial_r | {4'b0, b[5:0] & utd_pkg::CONT_BITS[5:0], 6'b0};
        pending_nxt = utd_pkg::PEND_ONE;
      end
    endcase
    if (item.text_last) begin
      pending_nxt = utd_pkg::PEND_NONE;
      partial_nxt = 16'h0000;
    end
  end

  assign res_valid      = take && (done || item.text_last);
  assign res.code_unit  = done ? unit : 16'h0000;
  assign res.unit_valid = done;
  assign res.text_end   = item.text_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= utd_pkg::PEND_NONE;
      partial_r <= 16'h0000;
    end else if (take) begin
      pending_r <= pending_nxt;
      partial_r <= partial_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: design/utd_out_reg.sv
// utd_out_reg: result register holding one code unit request for the sink
// depends on utd_pkg (result_t)
`default_nettype none

module utd_out_reg (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             load,
  input  wire utd_pkg::result_t res,
  output logic                  out_free,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [15:0]           out_code_unit,
  output logic                  out_unit_valid,
  output logic                  out_text_end
);

  logic             valid_r;
  logic             valid_nxt;
  utd_pkg::result_t res_r;

  // free when empty or when the held request leaves this cycle
  assign out_free       = !valid_r || out_ready;
  assign out_valid      = valid_r;
  assign out_code_unit  = res_r.code_unit;
  assign out_unit_valid = res_r.unit_valid;
  assign out_text_end   = res_r.text_end;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule

`default_nettype wire

FILE: design/utf8_to_utf16_stream_decoder.sv
// utf8_to_utf16_stream_decoder: top level, utf-8 bytes in, utf-16 code units out
// depends on utd_pkg, utd_in_reg, utd_core, utd_out_reg
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   in      | in_valid in_ready in_byte in_text_last  | sink
//   out     | out_valid out_ready out_code_unit       | source
//           | out_unit_valid out_text_end             |
//
// one byte per clock sustained while the sink keeps up; a byte passes from in to out through
// the input register, the decode and the result register
// bytes that finish nothing and are not last give no result
// reset clears the sequence count, accumulator and both valid flags
// a stalled sink holds the result register; the input register then fills and in_ready drops
`default_nettype none

module utf8_to_utf16_stream_decoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_byte,
  input  wire logic        in_text_last,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      out_code_unit,
  output logic             out_unit_valid,
  output logic             out_text_end
);

  logic             take;
  logic             item_valid;
  utd_pkg::item_t   item;
  logic             out_free;
  logic             res_valid;
  utd_pkg::result_t res;

  utd_in_reg u_in_reg (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte      (in_byte),
    .in_text_last (in_text_last),
    .take         (take),
    .item_valid   (item_valid),
    .item         (item)
  );

  utd_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .out_free   (out_free),
    .take       (take),
    .res_valid  (res_valid),
    .res        (res)
  );

  utd_out_reg u_out_reg (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (res_valid),
    .res            (res),
    .out_free       (out_free),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_code_unit  (out_code_unit),
    .out_unit_valid (out_unit_valid),
    .out_text_end   (out_text_end)
  );

endmodule

`default_nettype wire
